// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file sbda_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SBDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbda check failed");

// Next-cycle implication, disabled while reset is low.
`define SBDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbda check failed");

`endif

// ----- hdl/sbda_pkg.sv -----
package sbda_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	// double-dabble steps per pipeline stage
	localparam int BITS_PER_STAGE = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	localparam logic [3:0] DABBLE_LIMIT = 4'd5;
	localparam logic [3:0] DABBLE_ADD   = 4'd3;

	// decimal digits of 2**(w-1), the largest magnitude; 0.30103 ~ log10(2)
	function automatic int num_digits(input int w);
		return ((w - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

// ----- hdl/sbda_conv.sv -----
// Binary magnitude to BCD: negate, double-dabble stages, leading-digit search.
module sbda_conv #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic signed [VALUE_WIDTH-1:0]        value,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output logic                                 dn_neg,
	output logic [$clog2(sbda_pkg::num_digits(VALUE_WIDTH))-1:0] dn_lead,
	output logic [4*sbda_pkg::num_digits(VALUE_WIDTH)-1:0]       dn_bcd
);

	localparam int W   = VALUE_WIDTH;
	localparam int ND  = sbda_pkg::num_digits(W);
	localparam int BW  = 4 * ND;
	localparam int IW  = $clog2(ND);
	localparam int BPS = sbda_pkg::BITS_PER_STAGE;
	localparam int NST = (W + BPS - 1) / BPS;

	logic          en;
	logic          v_s1;
	logic          neg_s1;
	logic [W-1:0]  mag_s1;

	logic          dd_v_s   [1:NST];
	logic          dd_neg_s [1:NST];
	logic [BW-1:0] dd_bcd_s [1:NST];
	logic [W-1:0]  dd_bin_s [1:NST];

	logic [BW-1:0] stg_bcd_in [1:NST];
	logic [W-1:0]  stg_bin_in [1:NST];
	logic [BW-1:0] stg_bcd_nx [1:NST];
	logic [W-1:0]  stg_bin_nx [1:NST];

	logic          v_sl;
	logic          neg_sl;
	logic [IW-1:0] lead_sl;
	logic [BW-1:0] bcd_sl;
	logic [IW-1:0] lead_nx;

	// whole pipe advances together; stalls only when the tail is held
	assign en       = !v_sl || dn_ready;
	assign up_ready = en;

	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_stg
			localparam int LO    = (k - 1) * BPS;
			localparam int STEPS = ((W - LO) < BPS) ? (W - LO) : BPS;

			if (k == 1) begin : g_first
				assign stg_bcd_in[k] = '0;
				assign stg_bin_in[k] = mag_s1;
			end else begin : g_rest
				assign stg_bcd_in[k] = dd_bcd_s[k-1];
				assign stg_bin_in[k] = dd_bin_s[k-1];
			end

			logic [BW-1:0] b;
			logic [W-1:0]  m;
			always_comb begin
				b = stg_bcd_in[k];
				m = stg_bin_in[k];
				for (int j = 0; j < BPS; j++) begin
					if (j < STEPS) begin
						for (int d = 0; d < ND; d++) begin
							if (b[d*4 +: 4] >= sbda_pkg::DABBLE_LIMIT) begin
								b[d*4 +: 4] = b[d*4 +: 4] + sbda_pkg::DABBLE_ADD;
							end
						end
						b = {b[BW-2:0], m[W-1]};
						m = {m[W-2:0], 1'b0};
					end
				end
				stg_bcd_nx[k] = b;
				stg_bin_nx[k] = m;
			end
		end
	endgenerate

	// index of the top nonzero digit, zero when all digits are zero
	always_comb begin
		lead_nx = '0;
		for (int d = 0; d < ND; d++) begin
			if (dd_bcd_s[NST][d*4 +: 4] != 4'd0) begin
				lead_nx = IW'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 1; i <= NST; i++) begin
				dd_v_s[i] <= 1'b0;
			end
			v_sl <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
			dd_v_s[1] <= v_s1;
			for (int i = 2; i <= NST; i++) begin
				dd_v_s[i] <= dd_v_s[i-1];
			end
			v_sl <= dd_v_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= value[W-1];
			mag_s1 <= value[W-1] ? (~value + 1'b1) : value;
			dd_neg_s[1] <= neg_s1;
			for (int i = 2; i <= NST; i++) begin
				dd_neg_s[i] <= dd_neg_s[i-1];
			end
			for (int i = 1; i <= NST; i++) begin
				dd_bcd_s[i] <= stg_bcd_nx[i];
				dd_bin_s[i] <= stg_bin_nx[i];
			end
			neg_sl  <= dd_neg_s[NST];
			lead_sl <= lead_nx;
			bcd_sl  <= dd_bcd_s[NST];
		end
	end

	assign dn_valid = v_sl;
	assign dn_neg   = neg_sl;
	assign dn_lead  = lead_sl;
	assign dn_bcd   = bcd_sl;

endmodule

// ----- hdl/sbda_ser.sv -----
// Serializer: sign then digits from the top nonzero one, into an output register.
module sbda_ser #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic                                 up_neg,
	input  logic [$clog2(sbda_pkg::num_digits(VALUE_WIDTH))-1:0] up_lead,
	input  logic [4*sbda_pkg::num_digits(VALUE_WIDTH)-1:0]       up_bcd,
	output logic                                 char_valid,
	input  logic                                 char_ready,
	output logic [7:0]                           character,
	output logic                                 last
);

	localparam int ND = sbda_pkg::num_digits(VALUE_WIDTH);
	localparam int BW = 4 * ND;
	localparam int IW = $clog2(ND);

	logic          busy_q;
	logic          neg_q;
	logic [IW-1:0] idx_q;
	logic [BW-1:0] bcd_q;
	logic          ovld_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic out_free;
	logic emit;
	logic finishing;
	logic load;

	assign out_free  = !ovld_q || char_ready;
	assign emit      = busy_q && out_free;
	assign finishing = emit && !neg_q && (idx_q == '0);
	assign up_ready  = !busy_q || finishing;
	assign load      = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (char_ready) begin
				ovld_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (neg_q) begin
				char_q <= sbda_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sbda_pkg::CHAR_ZERO + {4'd0, bcd_q[idx_q*4 +: 4]};
				last_q <= (idx_q == '0);
			end
		end
		// a load only meets an emit on the final digit, whose cursor is done
		if (load) begin
			neg_q <= up_neg;
			idx_q <= up_lead;
			bcd_q <= up_bcd;
		end else if (emit) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign char_valid = ovld_q;
	assign character  = char_q;
	assign last       = last_q;

endmodule

// ----- hdl/signed_binary_to_decimal_ascii_top.sv -----
// Path: a taken word passes the input register, the double-dabble stage registers and the
//   leading-digit register, then loads into the serializer and its output register.
// Throughput: one character per cycle while char_ready is high; a word gives 1 to 11
//   characters at 32 bits, sent one at a time through the single-character output register.
// Reset: arst_n low clears all valid bits and the serializer at once; no result is pending.
//
// Structure
//   sbda_conv : stage 1 takes sign and magnitude (two's complement negate, the most
//               negative value comes out as its unsigned magnitude). Then ceil(W/4)
//               double-dabble stages, up to four shift/add-3 steps each, build the BCD digits.
//               A last stage finds the top nonzero digit so leading zeros are skipped;
//               an all-zero value points at digit 0 and gives a single '0'.
//               The whole pipe shares one advance enable, so a stall holds every stage
//               and nothing is lost or repeated. A new word may enter every cycle the
//               tail is free.
//   sbda_ser  : holds one converted word, emits '-' for negatives, then the digits from
//               the top nonzero one down, marking the final digit with last. It loads
//               the next word in the same cycle its final character goes out, and the
//               output register lets that happen as the previous character is taken.
module signed_binary_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          char_valid,
	input  logic                          char_ready,
	output logic [7:0]                    character,
	output logic                          last
);

	localparam int ND = sbda_pkg::num_digits(VALUE_WIDTH);
	localparam int IW = $clog2(ND);

	// converted word between the pipe and the serializer
	logic            cv_valid;
	logic            cv_ready;
	logic            cv_neg;
	logic [IW-1:0]   cv_lead;
	logic [4*ND-1:0] cv_bcd;

	sbda_conv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (value_valid),
		.up_ready (value_ready),
		.value    (value),
		.dn_valid (cv_valid),
		.dn_ready (cv_ready),
		.dn_neg   (cv_neg),
		.dn_lead  (cv_lead),
		.dn_bcd   (cv_bcd)
	);

	sbda_ser #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (cv_valid),
		.up_ready   (cv_ready),
		.up_neg     (cv_neg),
		.up_lead    (cv_lead),
		.up_bcd     (cv_bcd),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.last       (last)
	);

endmodule

// ----- hdl/sbda_chk.sv -----
`include "assert_macros.svh"

// Port-level checks on the word and character streams.
module sbda_chk #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          value_valid,
	input logic                          value_ready,
	input logic signed [VALUE_WIDTH-1:0] value,
	input logic                          char_valid,
	input logic                          char_ready,
	input logic [7:0]                    character,
	input logic                          last
);

	// high when the next character opens a number or its digits
	logic start_q;

	logic is_minus;
	logic is_zero;
	logic char_ok;
	logic in_wait;
	logic out_wait;

	assign is_minus = (character == sbda_pkg::CHAR_MINUS);
	assign is_zero  = (character == sbda_pkg::CHAR_ZERO);
	assign char_ok  = is_minus || ((character >= sbda_pkg::CHAR_ZERO) &&
		(character <= sbda_pkg::CHAR_ZERO + 8'd9));
	assign in_wait  = value_valid && !value_ready;
	assign out_wait = char_valid && !char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (char_valid && char_ready) begin
			start_q <= last || is_minus;
		end
	end

	`SBDA_ASSERT_IMP(a_char_set, clk, arst_n, char_valid, char_ok)
	`SBDA_ASSERT_IMP(a_minus_not_last, clk, arst_n, char_valid && is_minus, !last)
	`SBDA_ASSERT_IMP(a_no_lead_zero, clk, arst_n, char_valid && start_q && is_zero, last)
	`SBDA_ASSERT_NXT(a_out_hold, clk, arst_n, out_wait, char_valid && $stable({character, last}))
	`SBDA_ASSERT_NXT(a_in_hold, clk, arst_n, in_wait, value_valid && $stable(value))

endmodule

bind signed_binary_to_decimal_ascii_top sbda_chk #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_sbda_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_valid),
	.value_ready (value_ready),
	.value       (value),
	.char_valid  (char_valid),
	.char_ready  (char_ready),
	.character   (character),
	.last        (last)
);

// ----- sim/decimal_text_check.sv -----
`timescale 1ns / 1ps

module decimal_text_check #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   value_valid,
	input  logic                   value_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   char_valid,
	input  logic                   char_ready,
	input  logic [7:0]             character,
	input  logic                   last,
	output int                     mismatches,
	output int                     chars_owed
);

	localparam int RADIX     = 10;
	localparam int DIGIT_MAX = 24;

	typedef struct packed {
		logic [7:0] code;
		logic       tail;
	} text_char_t;

	// characters still to come, oldest first
	text_char_t owed_text[$];

	initial begin
		mismatches = 0;
		chars_owed = 0;
	end

	task automatic note_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// append the decimal text of one word
	function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] word);
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digs [DIGIT_MAX];
		int                     nd;
		int                     i;
		text_char_t             c;
		neg = word[VALUE_WIDTH-1];
		// most negative value wraps onto its own unsigned magnitude
		mag = neg ? (~word + 1'b1) : word;
		nd = 0;
		do begin
			digs[nd] = 4'(mag % RADIX);
			nd++;
			mag = mag / RADIX;
		end while (mag != 0 && nd < DIGIT_MAX);
		if (neg) begin
			c.code = sbda_pkg::CHAR_MINUS;
			c.tail = 1'b0;
			owed_text.push_back(c);
		end
		for (i = nd - 1; i >= 0; i--) begin
			c.code = sbda_pkg::CHAR_ZERO + 8'(digs[i]);
			c.tail = (i == 0);
			owed_text.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (value_valid && value_ready)
				spell_decimal(value);
			if (char_valid && char_ready) begin
				if (owed_text.size() == 0) begin
					note_mismatch($sformatf("unexpected character %0d last %0b",
						character, last));
				end else begin
					want = owed_text.pop_front();
					if (character !== want.code)
						note_mismatch($sformatf("character %0d, want %0d",
							character, want.code));
					if (last !== want.tail)
						note_mismatch($sformatf("last %0b on character %0d, want %0b",
							last, want.code, want.tail));
				end
			end
			chars_owed = owed_text.size();
		end
	end

endmodule

// ----- sim/signed_binary_to_decimal_ascii_top_test.sv -----
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_top_test;

	localparam int W            = sbda_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_WORDS = 480;
	localparam int DRAIN_AT     = 200;   // sender waits for an empty output here
	localparam int QUIET_AT     = 360;   // no idling on either side from here on
	localparam int TAIL_CYCLES  = 20;    // longer than the path from a taken word to its first character
	localparam int CYCLE_LIMIT  = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 value_valid;
	logic                 value_ready;
	logic signed [W-1:0]  value;
	logic                 char_valid;
	logic                 char_ready;
	logic [7:0]           character;
	logic                 last;

	int errors;
	int chars_owed;
	int cycle_count;
	bit quiet;

	signed_binary_to_decimal_ascii_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.character   (character),
		.last        (last)
	);

	// predicts the text of each taken word and checks every character
	decimal_text_check #(.VALUE_WIDTH(W)) check (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.character   (character),
		.last        (last),
		.mismatches  (errors),
		.chars_owed  (chars_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("signed_binary_to_decimal_ascii_top_test: done, errors");
		$finish;
	end

	// receiver: char_ready drops in bursts of random length until the quiet tail
	initial begin
		int stall_left;
		stall_left = 0;
		char_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				char_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(1, 13) - 1;
				char_ready <= 1'b0;
			end else begin
				char_ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge. Optionally idles the sender for a burst, then
	// offers the word and returns at the falling edge after it is taken with
	// valid still high, so a back-to-back word just overwrites the payload.
	task automatic send_word(input logic [W-1:0] w);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 13);
			value_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		value_valid <= 1'b1;
		value       <= w;
		@(posedge clk);
		while (!value_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// random words: full range, tiny values, digit-count boundaries,
	// fixed-length magnitudes and the two ends of the range
	function automatic logic [W-1:0] pick_value();
		logic [63:0] p;
		logic [63:0] span;
		logic [W-1:0] m;
		int k;
		bit neg;
		neg = $urandom_range(0, 1);
		m = '0;
		case ($urandom_range(0, 5))
			0, 1: begin
				return W'($urandom);
			end
			2: begin
				m = W'($urandom_range(0, 20));
			end
			3: begin
				// 10^k - 1, 10^k, 10^k + 1
				k = $urandom_range(1, 9);
				p = 1;
				repeat (k) p = p * 10;
				m = W'(p) - 1 + W'($urandom_range(0, 2));
			end
			4: begin
				k = $urandom_range(1, 9);
				p = 1;
				repeat (k - 1) p = p * 10;
				span = p * 9;
				m = W'(p + (64'($urandom) % span));
			end
			default: begin
				if ($urandom_range(0, 1))
					return {1'b1, {(W-1){1'b0}}} + W'($urandom_range(0, 3));
				return {1'b0, {(W-1){1'b1}}} - W'($urandom_range(0, 3));
			end
		endcase
		return neg ? -m : m;
	endfunction

	initial begin
		logic [W-1:0] directed [$];
		int i;
		arst_n      = 1'b0;
		value_valid = 1'b0;
		value       = '0;
		quiet       = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero, unit values, digit-count steps, both range ends (the most
		// negative one needs the unsigned magnitude), alternating bit patterns
		directed = '{
			32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd123456789,
			-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000,
			32'hFFFF_7FFF, 32'd2000000000
		};
		foreach (directed[j])
			send_word(directed[j]);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == DRAIN_AT) begin
				// hold off until the output has emptied
				value_valid <= 1'b0;
				@(negedge clk);
				while (chars_owed != 0) @(negedge clk);
			end
			if (i == QUIET_AT)
				quiet <= 1'b1;
			send_word(pick_value());
		end

		value_valid <= 1'b0;
		@(negedge clk);
		while (chars_owed != 0) @(negedge clk);
		// catch any stray character after the last expected one
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("signed_binary_to_decimal_ascii_top_test: done, clean");
		end else begin
			$display("signed_binary_to_decimal_ascii_top_test: done, errors");
		end
		$finish;
	end

endmodule
